// ===== sv/date_validate_and_difference_core_assert.svh =====
// ----------------------------------------------------------------------------
// date_validate_and_difference_core_assert.svh
// assertion macros shared by the date difference checker
// ----------------------------------------------------------------------------
`ifndef DATE_VALIDATE_AND_DIFFERENCE_CORE_ASSERT_SVH
`define DATE_VALIDATE_AND_DIFFERENCE_CORE_ASSERT_SVH

// condition holds in the same cycle as its trigger
`define DVD_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("date difference assertion failed");

// condition holds in the cycle after its trigger
`define DVD_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("date difference assertion failed");

`endif

// ===== sv/dvd_pkg.sv =====
// ----------------------------------------------------------------------------
// dvd_pkg
// types, codes and date helper functions for the date difference core
// ----------------------------------------------------------------------------
package dvd_pkg;

   localparam int DAY_W         = 7;
   localparam int DAY_DIGITS_W  = 2;
   localparam int MONTH_W       = 7;
   localparam int MON_DIGITS_W  = 2;
   localparam int YEAR_W        = 14;
   localparam int YEAR_DIGITS_W = 3;
   localparam int DAY_COUNT_W   = 5;
   localparam int MON_COUNT_W   = 4;
   localparam int PROD_W        = 27;

   // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_START_BAD = 2'd1,
      STATUS_END_BAD   = 2'd2,
      STATUS_ORDER     = 2'd3
   } status_type;

   typedef struct packed {
      logic [DAY_W-1:0]         day;
      logic [DAY_DIGITS_W-1:0]  day_digits;
      logic [MONTH_W-1:0]       month;
      logic [MON_DIGITS_W-1:0]  month_digits;
      logic [YEAR_W-1:0]        year;
      logic [YEAR_DIGITS_W-1:0] year_digits;
   } date_type;

   // gregorian leap test, remainder by 100 read from the fraction bits
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic [PROD_W-1:0] prod;
      logic              div100;
      logic [1:0]        cent_low;
      prod     = PROD_W'(year) * PROD_W'(RECIP_100);
      div100   = (prod[RECIP_SHIFT-1:11] == '0);
      cent_low = prod[RECIP_SHIFT+1:RECIP_SHIFT];
      return (year[1:0] == 2'd0) && (!div100 || (cent_low == 2'd0));
   endfunction

   function automatic logic date_ok(input date_type dt);
      logic [YEAR_W-1:0] ly;
      logic              ok;
      ly = dt.year;
      if (dt.year < YEAR_W'(20)) begin
         ly = dt.year + YEAR_W'(2000);
      end else if (dt.year < YEAR_W'(100)) begin
         ly = dt.year + YEAR_W'(1900);
      end
      ok = 1'b0;
      unique case (dt.month) inside
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: ok = (dt.day <= 7'd31);
         7'd4, 7'd6, 7'd9, 7'd11:                   ok = (dt.day <= 7'd30);
         7'd2: ok = (dt.day <= 7'd28) || ((dt.day == 7'd29) && is_leap(ly));
         default: ok = 1'b0;
      endcase
      return ok && (dt.day != '0)
         && ((dt.day_digits == 2'd1) || (dt.day_digits == 2'd2))
         && ((dt.month_digits == 2'd1) || (dt.month_digits == 2'd2))
         && ((dt.year_digits == 3'd2) || (dt.year_digits == 3'd4));
   endfunction

   // length of the month before the given one, january borrows from december
   function automatic logic [DAY_COUNT_W-1:0] prev_month_days(
      input logic [3:0] month,
      input logic       leap
   );
      logic [DAY_COUNT_W-1:0] days;
      unique case (month) inside
         4'd1, 4'd2, 4'd4, 4'd6, 4'd8, 4'd9, 4'd11: days = DAY_COUNT_W'(31);
         4'd3:    days = leap ? DAY_COUNT_W'(29) : DAY_COUNT_W'(28);
         default: days = DAY_COUNT_W'(30);
      endcase
      return days;
   endfunction

endpackage

// ===== sv/date_validate_and_difference_core.sv =====
// ----------------------------------------------------------------------------
// date_validate_and_difference_core
// validates two dates and returns their difference in years, months and days
// ----------------------------------------------------------------------------
// One result per date pair. rsp_valid rises once the pair has passed the input
// register, loaded at the accepting edge, and then the result register; a
// new pair is taken every cycle while the result side keeps up. The result
// register and the input register each hold one item; req_stall rises only when
// both are full and rsp_stall is high. The per-item path is the validity checks,
// one 14 x 13 bit constant multiply per leap test, and the borrow subtractions.
module date_validate_and_difference_core
   import dvd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [DAY_W-1:0]         req_start_day,
   input  logic [DAY_DIGITS_W-1:0]  req_start_day_digits,
   input  logic [MONTH_W-1:0]       req_start_month,
   input  logic [MON_DIGITS_W-1:0]  req_start_month_digits,
   input  logic [YEAR_W-1:0]        req_start_year,
   input  logic [YEAR_DIGITS_W-1:0] req_start_year_digits,
   input  logic [DAY_W-1:0]         req_end_day,
   input  logic [DAY_DIGITS_W-1:0]  req_end_day_digits,
   input  logic [MONTH_W-1:0]       req_end_month,
   input  logic [MON_DIGITS_W-1:0]  req_end_month_digits,
   input  logic [YEAR_W-1:0]        req_end_year,
   input  logic [YEAR_DIGITS_W-1:0] req_end_year_digits,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [DAY_COUNT_W-1:0]   rsp_day_count,
   output logic [MON_COUNT_W-1:0]   rsp_month_count,
   output logic [YEAR_W-1:0]        rsp_year_count
);

   logic                   in_valid_ff;
   date_type               in_start_ff;
   date_type               in_end_ff;
   logic                   out_valid_ff;
   status_type             out_status_ff;
   logic [DAY_COUNT_W-1:0] out_day_ff;
   logic [MON_COUNT_W-1:0] out_month_ff;
   logic [YEAR_W-1:0]      out_year_ff;

   logic                   out_load;
   logic                   in_load;
   date_type               in_start_in;
   date_type               in_end_in;
   status_type             out_status_in;
   logic [DAY_COUNT_W-1:0] out_day_in;
   logic [MON_COUNT_W-1:0] out_month_in;
   logic [YEAR_W-1:0]      out_year_in;

   logic                   start_ok;
   logic                   end_ok;
   logic                   start_later;
   logic                   day_borrow;
   logic                   month_borrow;
   logic [DAY_W-1:0]       day_end;
   logic [3:0]             month_end;
   logic [4:0]             month_adj;
   logic [YEAR_W-1:0]      year_diff;

   assign out_load  = !out_valid_ff || !rsp_stall;
   assign in_load   = !in_valid_ff || out_load;
   assign req_stall = !in_load;

   always_comb begin
      in_start_in = '{day: req_start_day, day_digits: req_start_day_digits,
                      month: req_start_month, month_digits: req_start_month_digits,
                      year: req_start_year, year_digits: req_start_year_digits};
      in_end_in   = '{day: req_end_day, day_digits: req_end_day_digits,
                      month: req_end_month, month_digits: req_end_month_digits,
                      year: req_end_year, year_digits: req_end_year_digits};
   end

   // validation and borrow difference on the registered pair
   always_comb begin
      start_ok    = date_ok(in_start_ff);
      end_ok      = date_ok(in_end_ff);
      start_later = (in_end_ff.year < in_start_ff.year)
         || ((in_end_ff.year == in_start_ff.year)
             && ((in_end_ff.month < in_start_ff.month)
                 || ((in_end_ff.month == in_start_ff.month)
                     && (in_end_ff.day < in_start_ff.day))));

      day_borrow = (in_end_ff.day < in_start_ff.day);
      day_end    = in_end_ff.day;
      if (day_borrow) begin
         day_end = in_end_ff.day + DAY_W'(prev_month_days(in_end_ff.month[3:0],
                                                          is_leap(in_end_ff.year)));
      end
      month_end    = in_end_ff.month[3:0] - {3'd0, day_borrow};
      month_borrow = (month_end < in_start_ff.month[3:0]);
      month_adj    = {1'b0, month_end} + (month_borrow ? 5'd12 : 5'd0);
      year_diff    = in_end_ff.year - in_start_ff.year - YEAR_W'(month_borrow);

      out_status_in = STATUS_OK;
      out_day_in    = '0;
      out_month_in  = '0;
      out_year_in   = '0;
      if (!start_ok) begin
         out_status_in = STATUS_START_BAD;
      end else if (!end_ok) begin
         out_status_in = STATUS_END_BAD;
      end else if (start_later) begin
         out_status_in = STATUS_ORDER;
      end else begin
         // a short borrowed month can leave the day below zero
         if (day_end >= in_start_ff.day) begin
            out_day_in = DAY_COUNT_W'(day_end - in_start_ff.day);
         end
         out_month_in = MON_COUNT_W'(month_adj - {1'b0, in_start_ff.month[3:0]});
         out_year_in  = year_diff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_load) begin
            in_valid_ff <= req_valid;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_start_ff <= in_start_in;
         in_end_ff   <= in_end_in;
      end
      if (out_load && in_valid_ff) begin
         out_status_ff <= out_status_in;
         out_day_ff    <= out_day_in;
         out_month_ff  <= out_month_in;
         out_year_ff   <= out_year_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_day_count   = out_day_ff;
   assign rsp_month_count = out_month_ff;
   assign rsp_year_count  = out_year_ff;

endmodule

// ===== sv/dvd_checker.sv =====
// ----------------------------------------------------------------------------
// dvd_checker
// port level checks on the result side of the date difference core
// ----------------------------------------------------------------------------
`include "date_validate_and_difference_core_assert.svh"

module dvd_checker
   import dvd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [1:0]             rsp_status,
   input logic [DAY_COUNT_W-1:0] rsp_day_count,
   input logic [MON_COUNT_W-1:0] rsp_month_count,
   input logic [YEAR_W-1:0]      rsp_year_count
);

   // a stalled item holds
   `DVD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_day_count) && $stable(rsp_month_count) && $stable(rsp_year_count))

   // error results carry no difference
   `DVD_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid && (rsp_status != STATUS_OK), (rsp_day_count == '0) && (rsp_month_count == '0) && (rsp_year_count == '0))

   // borrows keep days and months in range
   `DVD_ASSERT_SAME(a_ok_range, clock, reset, rsp_valid && (rsp_status == STATUS_OK), (rsp_day_count <= 5'd30) && (rsp_month_count <= 4'd11))

   // nothing comes out right after reset
   `DVD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind date_validate_and_difference_core dvd_checker u_dvd_checker (.*);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for date_validate_and_difference_core
// ----------------------------------------------------------------------------
// Sends date pairs over the valid/stall request channel and predicts each
// result in a scoreboard. Every returned difference is compared field by
// field, in order. A directed set covers leap days, borrows, bad digit counts
// and every status. Random pairs follow under four sender idle and receiver
// stall settings.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dvd_pkg::*;

   localparam int RANDOM_PER_PHASE = 100;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int NUM_PHASES       = 4;

   // sender idle and receiver stall percentages per phase
   localparam int unsigned SEND_IDLE_PCT [NUM_PHASES] = '{0, 46, 0, 32};
   localparam int unsigned RECV_STALL_PCT[NUM_PHASES] = '{0, 0, 46, 32};

   typedef struct {
      status_type               status;
      logic [DAY_COUNT_W-1:0]   days;
      logic [MON_COUNT_W-1:0]   months;
      logic [YEAR_W-1:0]        years;
   } date_diff_type;

   class date_diff_scoreboard;
      date_diff_type expected_diffs[$];
      int            mismatches;
      int            results_checked;
      int            status_seen[4];

      static function bit leap_year(int unsigned year);
         return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
      endfunction

      static function int month_days(int unsigned month, bit leap);
         case (month)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
         endcase
      endfunction

      // validation reads two-digit years as 20xx below 20 and 19xx up to 99
      static function int unsigned leap_test_year(int unsigned year);
         if (year < 20) return year + 2000;
         if (year < 100) return year + 1900;
         return year;
      endfunction

      static function bit date_valid(date_type dt);
         if (dt.day_digits != 2'd1 && dt.day_digits != 2'd2) return 1'b0;
         if (dt.month_digits != 2'd1 && dt.month_digits != 2'd2) return 1'b0;
         if (dt.year_digits != 3'd2 && dt.year_digits != 3'd4) return 1'b0;
         return (dt.day != 0) &&
            (dt.day <= month_days(dt.month, leap_year(leap_test_year(dt.year))));
      endfunction

      // raw years, no century adjustment
      static function bit date_later(date_type a, date_type b);
         return (a.year > b.year) || (a.year == b.year && a.month > b.month) ||
            (a.year == b.year && a.month == b.month && a.day > b.day);
      endfunction

      function date_diff_type predict_difference(date_type s, date_type e);
         date_diff_type r;
         int            end_day;
         int            end_month;
         int            end_year;
         int            prev_month;
         int            day_diff;
         r.status = STATUS_OK;
         r.days   = '0;
         r.months = '0;
         r.years  = '0;
         if (!date_valid(s)) begin
            r.status = STATUS_START_BAD;
         end else if (!date_valid(e)) begin
            r.status = STATUS_END_BAD;
         end else if (date_later(s, e)) begin
            r.status = STATUS_ORDER;
         end else begin
            end_day   = int'(e.day);
            end_month = int'(e.month);
            end_year  = int'(e.year);
            if (e.day < s.day) begin
               prev_month = end_month - 1;
               // a january end borrows the 31 days of december
               if (prev_month == 2) begin
                  end_day += leap_year(e.year) ? 29 : 28;
               end else if (prev_month == 0 || month_days(prev_month, 1'b0) == 31) begin
                  end_day += 31;
               end else begin
                  end_day += 30;
               end
               end_month -= 1;
            end
            if (end_month < int'(s.month)) begin
               end_month += 12;
               end_year  -= 1;
            end
            day_diff = end_day - int'(s.day);
            // a short borrowed month can leave the day part negative
            r.days   = (day_diff < 0) ? '0 : DAY_COUNT_W'(day_diff);
            r.months = MON_COUNT_W'(end_month - int'(s.month));
            r.years  = YEAR_W'(end_year - int'(s.year));
         end
         return r;
      endfunction

      function void note_request(date_type s, date_type e);
         date_diff_type exp;
         exp = predict_difference(s, e);
         status_seen[int'(exp.status)]++;
         expected_diffs.push_back(exp);
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_result(logic [1:0] status, logic [DAY_COUNT_W-1:0] days,
                                 logic [MON_COUNT_W-1:0] months,
                                 logic [YEAR_W-1:0] years);
         date_diff_type exp;
         results_checked++;
         if (expected_diffs.size() == 0) begin
            report($sformatf("unexpected result status %0d days %0d months %0d years %0d",
                             status, days, months, years));
            return;
         end
         exp = expected_diffs.pop_front();
         if (status !== 2'(exp.status) || days !== exp.days || months !== exp.months ||
             years !== exp.years) begin
            report($sformatf({"result %0d expected status %0d days %0d months %0d ",
                              "years %0d, got status %0d days %0d months %0d years %0d"},
                             results_checked, exp.status, exp.days, exp.months, exp.years,
                             status, days, months, years));
         end
      endfunction

      function int pending();
         return expected_diffs.size();
      endfunction

      function void flush_leftovers();
         date_diff_type exp;
         while (expected_diffs.size() != 0) begin
            exp = expected_diffs.pop_front();
            report($sformatf("missing result status %0d days %0d months %0d years %0d",
                             exp.status, exp.days, exp.months, exp.years));
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [DAY_W-1:0]         req_start_day = '0;
   logic [DAY_DIGITS_W-1:0]  req_start_day_digits = '0;
   logic [MONTH_W-1:0]       req_start_month = '0;
   logic [MON_DIGITS_W-1:0]  req_start_month_digits = '0;
   logic [YEAR_W-1:0]        req_start_year = '0;
   logic [YEAR_DIGITS_W-1:0] req_start_year_digits = '0;
   logic [DAY_W-1:0]         req_end_day = '0;
   logic [DAY_DIGITS_W-1:0]  req_end_day_digits = '0;
   logic [MONTH_W-1:0]       req_end_month = '0;
   logic [MON_DIGITS_W-1:0]  req_end_month_digits = '0;
   logic [YEAR_W-1:0]        req_end_year = '0;
   logic [YEAR_DIGITS_W-1:0] req_end_year_digits = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_status;
   logic [DAY_COUNT_W-1:0]   rsp_day_count;
   logic [MON_COUNT_W-1:0]   rsp_month_count;
   logic [YEAR_W-1:0]        rsp_year_count;

   date_diff_scoreboard sb = new();
   int unsigned         send_idle_pct = 0;
   int unsigned         stall_pct = 0;
   int                  pairs_sent = 0;

   always #2 clock = ~clock;

   date_validate_and_difference_core i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_start_day          (req_start_day),
      .req_start_day_digits   (req_start_day_digits),
      .req_start_month        (req_start_month),
      .req_start_month_digits (req_start_month_digits),
      .req_start_year         (req_start_year),
      .req_start_year_digits  (req_start_year_digits),
      .req_end_day            (req_end_day),
      .req_end_day_digits     (req_end_day_digits),
      .req_end_month          (req_end_month),
      .req_end_month_digits   (req_end_month_digits),
      .req_end_year           (req_end_year),
      .req_end_year_digits    (req_end_year_digits),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_day_count          (rsp_day_count),
      .rsp_month_count        (rsp_month_count),
      .rsp_year_count         (rsp_year_count)
   );

   function automatic date_type make_date(int d, int dd, int m, int md, int y, int yd);
      date_type dt;
      dt.day          = DAY_W'(d);
      dt.day_digits   = DAY_DIGITS_W'(dd);
      dt.month        = MONTH_W'(m);
      dt.month_digits = MON_DIGITS_W'(md);
      dt.year         = YEAR_W'(y);
      dt.year_digits  = YEAR_DIGITS_W'(yd);
      return dt;
   endfunction

   // a negative year_hint picks a random year
   function automatic date_type random_valid_date(int year_hint);
      date_type dt;
      int       len;
      dt.month        = MONTH_W'($urandom_range(12, 1));
      dt.month_digits = MON_DIGITS_W'($urandom_range(2, 1));
      dt.day_digits   = DAY_DIGITS_W'($urandom_range(2, 1));
      dt.year_digits  = $urandom_range(1) ? 3'd2 : 3'd4;
      if (year_hint >= 0) begin
         dt.year = YEAR_W'(year_hint);
      end else begin
         dt.year = YEAR_W'($urandom_range(1) ? $urandom_range(99) : $urandom_range(9999));
         // push some years onto multiples of four to reach leap days
         if ($urandom_range(3) == 0) dt.year[1:0] = 2'b00;
      end
      len = date_diff_scoreboard::month_days(dt.month, date_diff_scoreboard::leap_year(
               date_diff_scoreboard::leap_test_year(dt.year)));
      dt.day = DAY_W'(($urandom_range(3) == 0) ? len : $urandom_range(len, 1));
      return dt;
   endfunction

   function automatic void random_ordered_pair(output date_type s, output date_type e);
      date_type swap;
      int       end_year;
      s = random_valid_date(-1);
      if ($urandom_range(9) < 6) begin
         end_year = int'(s.year) + $urandom_range(3);
         if (end_year > 9999) end_year = int'(s.year);
         e = random_valid_date(end_year);
      end else begin
         e = random_valid_date(-1);
      end
      // a few pairs are left out of order
      if (date_diff_scoreboard::date_later(s, e) && $urandom_range(9) != 0) begin
         swap = s;
         s    = e;
         e    = swap;
      end
   endfunction

   function automatic void corrupt_date(inout date_type dt);
      int len;
      len = date_diff_scoreboard::month_days(dt.month, date_diff_scoreboard::leap_year(
               date_diff_scoreboard::leap_test_year(dt.year)));
      case ($urandom_range(5))
         0: dt.day_digits   = $urandom_range(1) ? 2'd0 : 2'd3;
         1: dt.month_digits = $urandom_range(1) ? 2'd0 : 2'd3;
         2: begin
            dt.year_digits = YEAR_DIGITS_W'($urandom_range(7));
            if (dt.year_digits == 3'd2 || dt.year_digits == 3'd4) dt.year_digits += 3'd1;
         end
         3: dt.month = $urandom_range(1) ? 7'd0 : MONTH_W'($urandom_range(99, 13));
         4: dt.day   = 7'd0;
         default: dt.day = DAY_W'($urandom_range(99, len + 1));
      endcase
   endfunction

   function automatic date_type noise_date();
      return make_date($urandom_range(99), $urandom_range(3), $urandom_range(99),
                       $urandom_range(3), $urandom_range(9999), $urandom_range(7));
   endfunction

   task automatic send_pair(date_type s, date_type e);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_start_day          <= s.day;
      req_start_day_digits   <= s.day_digits;
      req_start_month        <= s.month;
      req_start_month_digits <= s.month_digits;
      req_start_year         <= s.year;
      req_start_year_digits  <= s.year_digits;
      req_end_day            <= e.day;
      req_end_day_digits     <= e.day_digits;
      req_end_month          <= e.month;
      req_end_month_digits   <= e.month_digits;
      req_end_year           <= e.year;
      req_end_year_digits    <= e.year_digits;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(s, e);
      pairs_sent++;
   endtask

   task automatic run_directed();
      // leap day in a raw four-digit leap year, borrowing a leap february
      send_pair(make_date(29, 2, 2, 1, 2000, 4), make_date(1, 1, 3, 1, 2000, 4));
      // 1900 is not leap
      send_pair(make_date(29, 2, 2, 1, 1900, 4), make_date(1, 1, 1, 1, 2000, 4));
      // two-digit years read as 2000 and 2004
      send_pair(make_date(29, 2, 2, 2, 0, 2), make_date(29, 2, 2, 2, 4, 2));
      // 96 is leap as 1996, 19 is not as 2019
      send_pair(make_date(29, 2, 2, 2, 96, 2), make_date(29, 2, 2, 2, 19, 2));
      // both dates bad reports the start
      send_pair(make_date(29, 2, 2, 2, 19, 2), make_date(0, 1, 1, 1, 19, 2));
      // day part goes negative and saturates
      send_pair(make_date(31, 2, 1, 1, 2001, 4), make_date(1, 1, 3, 1, 2001, 4));
      send_pair(make_date(30, 2, 1, 1, 2001, 4), make_date(1, 1, 3, 1, 2001, 4));
      // january end borrows december, then a year
      send_pair(make_date(15, 2, 1, 2, 2020, 4), make_date(10, 2, 1, 2, 2021, 4));
      // thirty-day borrow
      send_pair(make_date(31, 2, 3, 1, 2010, 4), make_date(1, 1, 5, 1, 2010, 4));
      // order uses raw years
      send_pair(make_date(1, 1, 1, 1, 1999, 4), make_date(1, 1, 1, 1, 5, 2));
      send_pair(make_date(2, 1, 3, 1, 2000, 4), make_date(1, 1, 3, 1, 2000, 4));
      send_pair(make_date(1, 1, 5, 1, 2000, 4), make_date(1, 1, 4, 1, 2000, 4));
      send_pair(make_date(28, 2, 2, 1, 2023, 4), make_date(28, 2, 2, 1, 2023, 4));
      // widest difference
      send_pair(make_date(1, 1, 1, 1, 0, 4), make_date(31, 2, 12, 2, 9999, 4));
      // digit counts out of range
      send_pair(make_date(5, 0, 5, 1, 2000, 4), make_date(6, 1, 5, 1, 2000, 4));
      send_pair(make_date(5, 3, 5, 1, 2000, 4), make_date(6, 1, 5, 1, 2000, 4));
      send_pair(make_date(5, 1, 5, 1, 2000, 4), make_date(5, 1, 5, 0, 2001, 4));
      send_pair(make_date(5, 1, 5, 1, 2000, 4), make_date(5, 1, 5, 3, 2001, 4));
      send_pair(make_date(5, 1, 5, 1, 2000, 3), make_date(5, 1, 5, 1, 2001, 7));
      send_pair(make_date(5, 1, 5, 1, 2000, 4), make_date(5, 1, 5, 1, 2001, 0));
      // month and day out of range
      send_pair(make_date(5, 1, 0, 1, 2000, 4), make_date(5, 1, 13, 2, 2001, 4));
      send_pair(make_date(5, 1, 6, 1, 2000, 4), make_date(5, 1, 99, 2, 2001, 4));
      send_pair(make_date(32, 2, 1, 1, 2000, 4), make_date(1, 1, 2, 1, 2001, 4));
      send_pair(make_date(30, 2, 4, 1, 2000, 4), make_date(31, 2, 4, 1, 2001, 4));
      send_pair(make_date(99, 2, 11, 2, 9999, 4), make_date(31, 2, 11, 2, 9999, 4));
   endtask

   // result side: check accepted results, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_status, rsp_day_count, rsp_month_count, rsp_year_count);
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin
      date_type    s;
      date_type    e;
      int unsigned pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         send_idle_pct = SEND_IDLE_PCT[phase];
         stall_pct     = RECV_STALL_PCT[phase];
         repeat (RANDOM_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               random_ordered_pair(s, e);
            end else if (pick < 85) begin
               random_ordered_pair(s, e);
               if ($urandom_range(1)) corrupt_date(s);
               else corrupt_date(e);
            end else begin
               s = noise_date();
               e = noise_date();
            end
            send_pair(s, e);
         end
      end
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.flush_leftovers();
      $display("sent %0d date pairs over %0d idle/stall settings, checked %0d results",
               pairs_sent, NUM_PHASES, sb.results_checked);
      $display("status mix: ok %0d, start bad %0d, end bad %0d, out of order %0d; %0d mismatches",
               sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
